[rtl/core/lrupr_pkg.sv]
// ----------------------------------------------------------------------------
// LRU page replacement: shared package
// Default sizes, fixed field widths, engine states and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

	localparam int DEF_MAX_FRAME_SLOTS = 16;
	localparam int DEF_PAGE_BITS       = 16;
	localparam int DEF_STAMP_BITS      = 32;

	localparam int CFG_BITS      = 5;
	localparam int SLOT_OUT_BITS = 4;
	localparam int TOTAL_BITS    = 32;

	localparam logic [CFG_BITS-1:0] FRAMES_RESET = CFG_BITS'(4);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE,
		ST_DONE
	} eng_state_t;

	typedef struct packed {
		logic                      clear;
		logic [CFG_BITS-1:0]       frames;
	} cfg_ctl_t;

	typedef struct packed {
		logic                      hit;
		logic [SLOT_OUT_BITS-1:0]  frame_slot;
		logic                      evicted_valid;
		logic [TOTAL_BITS-1:0]     fault_total;
		logic [TOTAL_BITS-1:0]     hit_total;
	} res_status_t;

endpackage

`default_nettype wire

[rtl/core/lrupr_if.sv]
// ----------------------------------------------------------------------------
// LRU page replacement: channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrupr_req_if import lrupr_pkg::*; #(
	parameter int PAGE_BITS = DEF_PAGE_BITS
);
	logic                 valid;
	logic                 ready;
	logic [PAGE_BITS-1:0] page_number;

	modport source (output valid, output page_number, input ready);
	modport sink   (input valid, input page_number, output ready);
endinterface

interface lrupr_res_if import lrupr_pkg::*; #(
	parameter int PAGE_BITS = DEF_PAGE_BITS
);
	logic                     valid;
	logic                     ready;
	logic                     hit;
	logic [SLOT_OUT_BITS-1:0] frame_slot;
	logic                     evicted_valid;
	logic [PAGE_BITS-1:0]     evicted_page;
	logic [TOTAL_BITS-1:0]    fault_total;
	logic [TOTAL_BITS-1:0]    hit_total;

	modport source (output valid, output hit, output frame_slot, output evicted_valid,
		output evicted_page, output fault_total, output hit_total, input ready);
	modport sink   (input valid, input hit, input frame_slot, input evicted_valid,
		input evicted_page, input fault_total, input hit_total, output ready);
endinterface

interface lrupr_cfg_if import lrupr_pkg::*;;
	logic                valid;
	logic                ready;
	logic [CFG_BITS-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/lrupr_ram.sv]
// ----------------------------------------------------------------------------
// LRU page replacement: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                       wr_data,
	input  wire logic                                   rd_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output      logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/lrupr_engine.sv]
// ----------------------------------------------------------------------------
// LRU page replacement: lookup engine
// Scans the frame memory for a hit and the least-recent frame, writes back.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_engine import lrupr_pkg::*; #(
	parameter int MAX_FRAME_SLOTS = DEF_MAX_FRAME_SLOTS,
	parameter int PAGE_BITS       = DEF_PAGE_BITS,
	parameter int STAMP_BITS      = DEF_STAMP_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cfg_ctl_t             cfg_ctl,
	input  wire logic                 req_valid,
	input  wire logic [PAGE_BITS-1:0] req_page,
	output      logic                 req_ready,
	output      logic                 res_valid,
	input  wire logic                 res_take,
	output      res_status_t          res_status,
	output      logic [PAGE_BITS-1:0] res_ev_page
);

	localparam int SLOT_BITS  = (MAX_FRAME_SLOTS > 1) ? $clog2(MAX_FRAME_SLOTS) : 1;
	localparam int CNT_BITS   = $clog2(MAX_FRAME_SLOTS + 1);
	localparam int ENTRY_BITS = PAGE_BITS + STAMP_BITS;

	eng_state_t state_q, state_d;

	logic [CNT_BITS-1:0]        n_active;
	logic                       rd_en, wr_en, last_rd;
	logic [ENTRY_BITS-1:0]      rd_data;
	logic [SLOT_BITS-1:0]       sel_slot;

	logic [PAGE_BITS-1:0]       page_q;
	logic [STAMP_BITS-1:0]      stamp_q;
	logic [SLOT_BITS-1:0]       rd_idx_q;
	logic                       rd_vld_s1;
	logic [SLOT_BITS-1:0]       idx_s1;
	logic                       found_q;
	logic [SLOT_BITS-1:0]       found_slot_q;
	logic                       best_valid_q;
	logic [SLOT_BITS-1:0]       best_slot_q;
	logic [STAMP_BITS-1:0]      best_stamp_q;
	logic [PAGE_BITS-1:0]       best_page_q;
	logic [MAX_FRAME_SLOTS-1:0] frame_valid_q;
	logic [TOTAL_BITS-1:0]      fault_q, hit_q, fault_next, hit_next;
	res_status_t                status_q;
	logic [PAGE_BITS-1:0]       ev_page_q;

	logic                       ent_valid, ent_match, evict;
	logic [PAGE_BITS-1:0]       ent_page;
	logic [STAMP_BITS-1:0]      ent_stamp;

	always_comb begin
		if (cfg_ctl.frames == '0) begin
			n_active = CNT_BITS'(1);
		end else if (int'(cfg_ctl.frames) > MAX_FRAME_SLOTS) begin
			n_active = CNT_BITS'(MAX_FRAME_SLOTS);
		end else begin
			n_active = CNT_BITS'(cfg_ctl.frames);
		end
	end

	assign last_rd   = (CNT_BITS'(rd_idx_q) + CNT_BITS'(1)) == n_active;
	assign ent_valid = frame_valid_q[idx_s1];
	assign ent_page  = rd_data[ENTRY_BITS-1 -: PAGE_BITS];
	assign ent_stamp = ent_valid ? rd_data[STAMP_BITS-1:0] : '0;
	assign ent_match = ent_valid && (ent_page == page_q);
	assign sel_slot  = found_q ? found_slot_q : best_slot_q;
	assign evict     = !found_q && best_valid_q;

	always_comb begin
		fault_next = fault_q;
		hit_next   = hit_q;
		if (found_q) begin
			if (hit_q != '1) begin
				hit_next = hit_q + TOTAL_BITS'(1);
			end
		end else begin
			if (fault_q != '1) begin
				fault_next = fault_q + TOTAL_BITS'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (req_valid) state_d = ST_SCAN;
			ST_SCAN:  if (last_rd) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_WRITE;
			ST_WRITE: state_d = ST_DONE;
			ST_DONE:  if (res_take) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE:  req_ready = 1'b1;
			ST_SCAN:  rd_en     = 1'b1;
			ST_WRITE: wr_en     = 1'b1;
			ST_DONE:  res_valid = 1'b1;
			default:  req_ready = 1'b0;
		endcase
	end

	lrupr_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (MAX_FRAME_SLOTS)
	) u_frame_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (sel_slot),
		.wr_data ({page_q, stamp_q}),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rd_vld_s1     <= 1'b0;
			frame_valid_q <= '0;
			stamp_q       <= '0;
			fault_q       <= '0;
			hit_q         <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (req_valid && req_ready && (stamp_q != '1)) begin
				stamp_q <= stamp_q + STAMP_BITS'(1);
			end
			if (wr_en) begin
				fault_q <= fault_next;
				hit_q   <= hit_next;
			end
			if (cfg_ctl.clear) begin
				frame_valid_q <= '0;
			end else if (wr_en) begin
				frame_valid_q[sel_slot] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			page_q   <= req_page;
			rd_idx_q <= '0;
			found_q  <= 1'b0;
		end
		if (rd_en) begin
			rd_idx_q <= rd_idx_q + SLOT_BITS'(1);
			idx_s1   <= rd_idx_q;
		end
		if (rd_vld_s1) begin
			if (ent_match && !found_q) begin
				found_q      <= 1'b1;
				found_slot_q <= idx_s1;
			end
			if ((idx_s1 == '0) || (ent_stamp < best_stamp_q)) begin
				best_valid_q <= ent_valid;
				best_slot_q  <= idx_s1;
				best_stamp_q <= ent_stamp;
				best_page_q  <= ent_page;
			end
		end
		if (wr_en) begin
			status_q.hit           <= found_q;
			status_q.frame_slot    <= SLOT_OUT_BITS'(sel_slot);
			status_q.evicted_valid <= evict;
			status_q.fault_total   <= fault_next;
			status_q.hit_total     <= hit_next;
			ev_page_q              <= evict ? best_page_q : '0;
		end
	end

	assign res_status  = status_q;
	assign res_ev_page = ev_page_q;

endmodule

`default_nettype wire

[rtl/core/lru_page_replacement_top.sv]
// ----------------------------------------------------------------------------
// LRU page replacement: top level
// Page reference in, hit/fault report out, frame count register.
// ----------------------------------------------------------------------------
// Usage:
//   request carries one page number per request; result returns one report
//   per request: hit flag, frame used, evicted page and running totals.
//   cfg writes the frame count (0 acts as 1, values above the frame
//   capacity act as the capacity); a write empties every frame but keeps
//   the totals and the reference count. Write it only while idle.
//   Timing: a request runs in steps: accept it, read every active frame
//   from the frame memory through its single read port, take in the last
//   read data, write the chosen frame back, hand the report to the output
//   register. The next request is accepted in the cycle after the hand-off,
//   the same cycle in which the report reaches result; it can wait there
//   while the next request runs. Reset empties all frames, clears totals
//   and reference count, and sets the frame count to 4. If result stalls,
//   the report holds in the output register; a finished request behind it
//   holds in the engine and request stays low until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement_top import lrupr_pkg::*; #(
	parameter int MAX_FRAME_SLOTS = DEF_MAX_FRAME_SLOTS,
	parameter int PAGE_BITS       = DEF_PAGE_BITS,
	parameter int STAMP_BITS      = DEF_STAMP_BITS
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lrupr_cfg_if.sink  cfg,
	lrupr_req_if.sink  request,
	lrupr_res_if.source result
);

	logic [CFG_BITS-1:0]  frames_q;
	cfg_ctl_t             cfg_ctl;
	logic                 eng_valid, eng_take;
	res_status_t          eng_status;
	logic [PAGE_BITS-1:0] eng_ev_page;

	logic                 out_valid_q;
	res_status_t          out_status_q;
	logic [PAGE_BITS-1:0] out_page_q;

	assign cfg.ready      = 1'b1;
	assign cfg_ctl.clear  = cfg.valid;
	assign cfg_ctl.frames = frames_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
		end else if (cfg.valid) begin
			frames_q <= cfg.data;
		end
	end

	lrupr_engine #(
		.MAX_FRAME_SLOTS (MAX_FRAME_SLOTS),
		.PAGE_BITS       (PAGE_BITS),
		.STAMP_BITS      (STAMP_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_ctl     (cfg_ctl),
		.req_valid   (request.valid),
		.req_page    (request.page_number),
		.req_ready   (request.ready),
		.res_valid   (eng_valid),
		.res_take    (eng_take),
		.res_status  (eng_status),
		.res_ev_page (eng_ev_page)
	);

	assign eng_take = eng_valid && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_take) begin
			out_status_q <= eng_status;
			out_page_q   <= eng_ev_page;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.hit           = out_status_q.hit;
	assign result.frame_slot    = out_status_q.frame_slot;
	assign result.evicted_valid = out_status_q.evicted_valid;
	assign result.evicted_page  = out_page_q;
	assign result.fault_total   = out_status_q.fault_total;
	assign result.hit_total     = out_status_q.hit_total;

endmodule

`default_nettype wire

[test/tb_lru_page_replacement_top.sv]
// ----------------------------------------------------------------------------
// LRU page replacement: self-checking testbench
// Sends page references through the request channel and checks every report
// on the result channel against an in-bench LRU tracker. The tracker holds its
// own frames, stamps and totals. The frame count is rewritten between phases,
// including 0, 1, 16 and 31. Both sides idle and stall at random, and one
// phase holds the result side off long enough to back the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lru_page_replacement_top import lrupr_pkg::*;;

	localparam int SLOTS = DEF_MAX_FRAME_SLOTS;
	localparam int PAGE_W = DEF_PAGE_BITS;

	typedef struct packed {
		logic                     hit;
		logic [SLOT_OUT_BITS-1:0] frame_slot;
		logic                     evicted_valid;
		logic [PAGE_W-1:0]        evicted_page;
		logic [TOTAL_BITS-1:0]    fault_total;
		logic [TOTAL_BITS-1:0]    hit_total;
	} page_report_t;

	logic clk;
	logic arst_n;

	lrupr_cfg_if cfg_bus ();
	lrupr_req_if #(.PAGE_BITS(PAGE_W)) req_bus ();
	lrupr_res_if #(.PAGE_BITS(PAGE_W)) res_bus ();

	lru_page_replacement_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.request (req_bus),
		.result  (res_bus)
	);

	// tracker state
	logic [PAGE_W-1:0]     frame_pg  [SLOTS] = '{default: '0};
	bit                    frame_vld [SLOTS] = '{default: 1'b0};
	logic [31:0]           frame_stp [SLOTS] = '{default: '0};
	logic [31:0]           ref_count   = '0;
	logic [TOTAL_BITS-1:0] fault_count = '0;
	logic [TOTAL_BITS-1:0] hit_count   = '0;
	logic [CFG_BITS-1:0]   frames_reg  = FRAMES_RESET;

	page_report_t pending_reports[$];
	int mismatch_count = 0;
	int references_sent = 0;
	int reports_seen = 0;
	int hits_seen = 0;
	int settings_written = 0;
	int hold_off_cycles = 0;
	bit idle_on = 1'b1;

	function automatic int unsigned active_frame_count(input logic [CFG_BITS-1:0] v);
		if (v == 0)
			return 1;
		if (v > SLOTS)
			return SLOTS;
		return 32'(v);
	endfunction

	function automatic page_report_t lru_lookup(input logic [PAGE_W-1:0] pg);
		page_report_t r;
		int unsigned n;
		int unsigned slot;
		int unsigned j;
		bit found;
		n = active_frame_count(frames_reg);
		r = '0;
		slot = 0;
		found = 1'b0;
		if (ref_count != '1)
			ref_count = ref_count + 1;
		for (j = 0; j < n; j++) begin
			if (!found && frame_vld[j] && frame_pg[j] == pg) begin
				found = 1'b1;
				slot = j;
			end
		end
		if (found) begin
			frame_stp[slot] = ref_count;
			if (hit_count != '1)
				hit_count = hit_count + 1;
		end else begin
			// least recent stamp, lowest index on a tie
			for (j = 1; j < n; j++) begin
				if (frame_stp[j] < frame_stp[slot])
					slot = j;
			end
			if (frame_vld[slot]) begin
				r.evicted_valid = 1'b1;
				r.evicted_page = frame_pg[slot];
			end
			frame_pg[slot] = pg;
			frame_vld[slot] = 1'b1;
			frame_stp[slot] = ref_count;
			if (fault_count != '1)
				fault_count = fault_count + 1;
		end
		r.hit = found;
		r.frame_slot = SLOT_OUT_BITS'(slot);
		r.fault_total = fault_count;
		r.hit_total = hit_count;
		return r;
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, what, want, got);
			mismatch_count++;
		end
	endfunction

	task automatic check_report();
		page_report_t want;
		if (pending_reports.size() == 0) begin
			$display("%0t ns: result with no request outstanding, expected none actual slot %0d",
				$time, res_bus.frame_slot);
			mismatch_count++;
			return;
		end
		want = pending_reports.pop_front();
		reports_seen++;
		if (want.hit)
			hits_seen++;
		check_field("hit", 32'(want.hit), 32'(res_bus.hit));
		check_field("frame_slot", 32'(want.frame_slot), 32'(res_bus.frame_slot));
		check_field("evicted_valid", 32'(want.evicted_valid), 32'(res_bus.evicted_valid));
		check_field("evicted_page", 32'(want.evicted_page), 32'(res_bus.evicted_page));
		check_field("fault_total", want.fault_total, res_bus.fault_total);
		check_field("hit_total", want.hit_total, res_bus.hit_total);
	endtask

	task automatic send_page(input logic [PAGE_W-1:0] pg);
		while (idle_on && $urandom_range(99) < 19) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.page_number <= pg;
		do
			@(posedge clk);
		while (!req_bus.ready);
		pending_reports.push_back(lru_lookup(pg));
		references_sent++;
	endtask

	// hold requests back until every report is in, then let the engine settle
	task automatic drain_reports();
		req_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_frame_count(input logic [CFG_BITS-1:0] v);
		drain_reports();
		cfg_bus.valid <= 1'b1;
		cfg_bus.data <= v;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		frames_reg = v;
		for (int i = 0; i < SLOTS; i++) begin
			frame_pg[i] = '0;
			frame_vld[i] = 1'b0;
			frame_stp[i] = '0;
		end
		settings_written++;
	endtask

	task automatic test_reset_frame_count();
		// page 0 against empty frames must still miss
		send_page(16'h0000);
		send_page(16'hFFFF);
		send_page(16'h0001);
		send_page(16'h0002);
		send_page(16'h0000);
		send_page(16'h0003);
		send_page(16'h0004);
		send_page(16'hFFFF);
	endtask

	task automatic test_frame_count_extremes();
		write_frame_count(5'd0);
		send_page(16'd5);
		send_page(16'd5);
		send_page(16'd6);
		send_page(16'd5);
		write_frame_count(5'd1);
		send_page(16'hFFFF);
		send_page(16'h8000);
		write_frame_count(5'd31);
		send_page(16'd7);
		send_page(16'd7);
	endtask

	task automatic test_random_references();
		logic [CFG_BITS-1:0] setting;
		int unsigned n;
		int unsigned span;
		logic [PAGE_W-1:0] base;
		for (int phase = 0; phase < 12; phase++) begin
			case (phase)
				0: setting = 5'd16;
				1: setting = 5'd1;
				2: setting = 5'd0;
				3: setting = 5'd31;
				4: setting = 5'd17;
				default: setting = CFG_BITS'($urandom_range(31));
			endcase
			write_frame_count(setting);
			n = active_frame_count(setting);
			idle_on = (phase != 6);
			base = PAGE_W'($urandom_range(16'hFFD0));
			span = $urandom_range(1, n + 4);
			for (int k = 0; k < 150; k++) begin
				if ($urandom_range(99) < 15) begin
					send_page(PAGE_W'($urandom_range(16'hFFFF)));
				end else begin
					if ($urandom_range(99) < 3) begin
						base = PAGE_W'($urandom_range(16'hFFD0));
						span = $urandom_range(1, n + 4);
					end
					send_page(base + PAGE_W'($urandom_range(span - 1)));
				end
			end
			idle_on = 1'b1;
		end
	endtask

	task automatic test_result_backpressure();
		write_frame_count(5'd4);
		hold_off_cycles = 300;
		for (int k = 0; k < 30; k++)
			send_page(PAGE_W'(16'h1200 + $urandom_range(5)));
		drain_reports();
		for (int k = 0; k < 10; k++)
			send_page(PAGE_W'(16'h1200 + $urandom_range(5)));
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb_lru_page_replacement_top: errors");
		$finish;
	end

	// result side: check each report, stall at random or for a hold-off
	initial begin
		res_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_bus.valid && res_bus.ready)
				check_report();
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= !(idle_on && $urandom_range(99) < 19);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.data <= '0;
		req_bus.valid <= 1'b0;
		req_bus.page_number <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_frame_count();
		test_frame_count_extremes();
		test_random_references();
		test_result_backpressure();
		drain_reports();

		$display("covered %0d references: %0d hits, %0d faults, %0d frame-count writes",
			references_sent, hits_seen, reports_seen - hits_seen, settings_written);
		$display("frame counts 0, 1, 16, 17, 31 and random; result stalls up to 300 cycles");
		if (mismatch_count == 0)
			$display("tb_lru_page_replacement_top: clean");
		else
			$display("tb_lru_page_replacement_top: errors");
		$finish;
	end

endmodule
